@@ rtl/core/vdlt_pkg.sv @@
package vdlt_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned MAX_VBYTES = 5;
    localparam int unsigned VCNT_W     = 3;

    localparam logic [1:0] FLD_OFFSET = 2'd0;
    localparam logic [1:0] FLD_LINE   = 2'd1;
    localparam logic [1:0] FLD_COLUMN = 2'd2;

    localparam int unsigned QDEPTH  = 2;
    localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic [1:0]        field;
        logic              done;
        logic              last;
    } vdlt_entry_t;

    function automatic logic [WORD_W-1:0] zigzag_decode(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] half;
        half = {1'b0, v[WORD_W-1:1]};
        return v[0] ? ~half : half;
    endfunction

endpackage

@@ rtl/core/varint_delta_line_table_lookup.sv @@
// Line table lookup over varint / zigzag delta triples.
// Input channel: one table byte per word (table_byte, table_end on the final
//   byte), in_valid / in_stall. Output channel: one word per table with
//   line_number, column_number and passed_target, out_valid / out_stall.
// Config: cfg_wr_en / cfg_wr_data load target_offset; write only while idle.
// Throughput: one byte per cycle while in_stall is low. The front decodes varints and pushes each
//   finished field (or the final byte) into a 2-word queue; the back sums
//   deltas, compares with the target and owns the output register.
// The byte that completes the passing triple or ends the table is written into the queue;
//   the result word is loaded into the output register when the back pops it from the head.
// Bytes after the answer are dropped until the final byte of the table.
// Stall: a held output stalls the back once the next result word reaches the
//   queue head; in_stall rises when the queue holds that word and one more.
//   Payload holds while stalled.
// Reset: all sums, decode state and the queue clear; target_offset is 0.
module varint_delta_line_table_lookup (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         table_byte,
    input  logic               table_end,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] line_number,
    output logic signed [31:0] column_number,
    output logic               passed_target
);
    import vdlt_pkg::*;

    logic        q_push;
    logic        q_pop;
    logic        q_valid;
    logic        q_full;
    vdlt_entry_t push_entry;
    vdlt_entry_t head;

    vdlt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .table_byte (table_byte),
        .table_end  (table_end),
        .q_full     (q_full),
        .push       (q_push),
        .push_entry (push_entry)
    );

    vdlt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .q_valid    (q_valid),
        .q_full     (q_full),
        .head       (head)
    );

    vdlt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .q_valid       (q_valid),
        .head          (head),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .line_number   (line_number),
        .column_number (column_number),
        .passed_target (passed_target)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");

    a_pop_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    a_result_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(q_pop))
        else $error("result word without a queue pop");

    a_end_byte_pushed: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && table_end) |-> q_push)
        else $error("final byte not forwarded to back end");

endmodule

@@ rtl/core/vdlt_front.sv @@
module vdlt_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            table_byte,
    input  logic                  table_end,
    input  logic                  q_full,
    output logic                  push,
    output vdlt_pkg::vdlt_entry_t push_entry
);
    import vdlt_pkg::*;

    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [VCNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]        fld_reg, fld_next;

    logic              accept;
    logic              done;
    logic [5:0]        shamt;
    logic [WORD_W-1:0] shifted;
    logic [WORD_W-1:0] vint;

    always_comb
    begin
        accept = in_valid && !q_full;
        done   = !table_byte[7];
        shamt  = {cnt_reg, 3'b000} - {3'b000, cnt_reg};
        if (cnt_reg < VCNT_W'(MAX_VBYTES))
        begin
            shifted = WORD_W'(table_byte[6:0]) << shamt;
        end
        else
        begin
            shifted = '0;
        end
        vint = acc_reg | shifted;

        push_entry.value = (fld_reg == FLD_OFFSET) ? vint : zigzag_decode(vint);
        push_entry.field = fld_reg;
        push_entry.done  = done;
        push_entry.last  = table_end;
        push = accept && (done || table_end);

        acc_next = acc_reg;
        cnt_next = cnt_reg;
        fld_next = fld_reg;
        if (accept)
        begin
            if (table_end)
            begin
                acc_next = '0;
                cnt_next = '0;
                fld_next = FLD_OFFSET;
            end
            else if (done)
            begin
                acc_next = '0;
                cnt_next = '0;
                fld_next = (fld_reg == FLD_COLUMN) ? FLD_OFFSET : fld_reg + 2'd1;
            end
            else
            begin
                acc_next = vint;
                if (cnt_reg < VCNT_W'(MAX_VBYTES))
                begin
                    cnt_next = cnt_reg + VCNT_W'(1);
                end
            end
        end
    end

    assign in_stall = q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
            fld_reg <= FLD_OFFSET;
        end
        else
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            fld_reg <= fld_next;
        end
    end

endmodule

@@ rtl/core/vdlt_queue.sv @@
module vdlt_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  vdlt_pkg::vdlt_entry_t push_entry,
    input  logic                  pop,
    output logic                  q_valid,
    output logic                  q_full,
    output vdlt_pkg::vdlt_entry_t head
);
    import vdlt_pkg::*;

    vdlt_entry_t       slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_comb
    begin
        q_valid     = (cnt_reg != '0);
        q_full      = (cnt_reg == QCNT_W'(QDEPTH));
        head        = slot_reg[rd_ptr_reg];
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ rtl/core/vdlt_back.sv @@
module vdlt_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [31:0]           cfg_wr_data,
    input  logic                  q_valid,
    input  vdlt_pkg::vdlt_entry_t head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [31:0]    line_number,
    output logic signed [31:0]    column_number,
    output logic                  passed_target
);
    import vdlt_pkg::*;

    logic [WORD_W-1:0] target_reg;
    logic [WORD_W-1:0] pend_off_reg, pend_off_next;
    logic [WORD_W-1:0] pend_line_reg, pend_line_next;
    logic [WORD_W-1:0] off_sum_reg, off_sum_next;
    logic [WORD_W-1:0] line_sum_reg, line_sum_next;
    logic [WORD_W-1:0] col_sum_reg, col_sum_next;
    logic              ans_reg, ans_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] line_out_reg, col_out_reg;
    logic              passed_reg;

    logic              live;
    logic              col_triple;
    logic              passed;
    logic              accum;
    logic              emit;
    logic [WORD_W-1:0] sum_off;
    logic [WORD_W-1:0] sum_line;
    logic [WORD_W-1:0] sum_col;
    logic [WORD_W-1:0] line_res;
    logic [WORD_W-1:0] col_res;

    always_comb
    begin
        live       = q_valid && !ans_reg;
        col_triple = live && head.done && (head.field == FLD_COLUMN);
        sum_off    = off_sum_reg + pend_off_reg;
        sum_line   = line_sum_reg + pend_line_reg;
        sum_col    = col_sum_reg + head.value;
        passed     = col_triple && (sum_off > target_reg);
        accum      = col_triple && !passed;
        emit       = live && (passed || head.last);
        pop        = q_valid && (!emit || !out_valid_reg || !out_stall);
        line_res   = accum ? sum_line : line_sum_reg;
        col_res    = accum ? sum_col : col_sum_reg;

        pend_off_next  = pend_off_reg;
        pend_line_next = pend_line_reg;
        off_sum_next   = off_sum_reg;
        line_sum_next  = line_sum_reg;
        col_sum_next   = col_sum_reg;
        ans_next       = ans_reg;
        if (pop)
        begin
            if (head.last)
            begin
                pend_off_next  = '0;
                pend_line_next = '0;
                off_sum_next   = '0;
                line_sum_next  = '0;
                col_sum_next   = '0;
                ans_next       = 1'b0;
            end
            else if (live && head.done)
            begin
                unique case (head.field)
                    FLD_OFFSET: pend_off_next = head.value;
                    FLD_LINE:   pend_line_next = head.value;
                    FLD_COLUMN:
                    begin
                        if (passed)
                        begin
                            ans_next = 1'b1;
                        end
                        else
                        begin
                            off_sum_next  = sum_off;
                            line_sum_next = sum_line;
                            col_sum_next  = sum_col;
                        end
                    end
                    default: ans_next = ans_reg;
                endcase
            end
        end

        if (pop && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            pend_off_reg  <= '0;
            pend_line_reg <= '0;
            off_sum_reg   <= '0;
            line_sum_reg  <= '0;
            col_sum_reg   <= '0;
            ans_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                target_reg <= cfg_wr_data;
            end
            pend_off_reg  <= pend_off_next;
            pend_line_reg <= pend_line_next;
            off_sum_reg   <= off_sum_next;
            line_sum_reg  <= line_sum_next;
            col_sum_reg   <= col_sum_next;
            ans_reg       <= ans_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            line_out_reg <= line_res;
            col_out_reg  <= col_res;
            passed_reg   <= passed;
        end
    end

    assign out_valid     = out_valid_reg;
    assign line_number   = $signed(line_out_reg);
    assign column_number = $signed(col_out_reg);
    assign passed_target = passed_reg;

endmodule
